/* rtl/apdf_pkg.sv */
// Shared constants for the allpass delay filter: register map, field widths
// and fixed-point rounding constants.
// No dependencies; allpass_delay_filter imports this package.
`timescale 1ns / 1ps
`default_nettype none

package apdf_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEFAULT_MAX_DELAY    = 4096;
    localparam int DEFAULT_SAMPLE_WIDTH = 16;

    // Configuration port layout.
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    // Register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN         = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DELAY_LENGTH = 2'd1;

    // Register field widths and reset values.
    localparam int GAIN_WIDTH  = 16;
    localparam int DELAY_WIDTH = 13;
    localparam logic [DELAY_WIDTH-1:0] DELAY_RESET = 13'd1;

    // Q1.15 arithmetic: fraction bits, round-half-up bias and the value one.
    localparam int FRAC_BITS  = 15;
    localparam int ROUND_BIAS = 16384;
    localparam int ONE_Q15    = 32768;

endpackage

`default_nettype wire

/* rtl/apdf_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; storage has no reset.
`timescale 1ns / 1ps
`default_nettype none

module apdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/allpass_delay_filter.sv */
// Allpass delay filter:
//   y = -g*x + (1 - g*g) * (x delayed D + g * y delayed D), Q1.15 fixed point.
// Input channel: sample_valid / sample_stall with sample_in. A request is taken
// at a rising edge with sample_valid high and sample_stall low.
// Output channel: result_valid / result_stall with sample_out and saturated,
// held in an output register until the receiver takes it.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is
// the gain, index 1 the delay length. Writing the delay empties both rings.
// A pending configuration write holds off new sample requests for that cycle.
// Timing: requests do not overlap; one is taken only in the idle state. The
// history RAM answers in the read state (three products), the sum state
// forms the delayed sum, and the final state does the last product, saturates
// and writes the ring back. The single history RAM is read once and written
// once per request.
// A stalled receiver holds a finished result; the next request is still
// taken and runs until its write-back, where it waits for the output register.
// Reset: gain 0, delay 1, empty rings. Ring contents are tracked with a fill
// count, so no clearing pass is needed and the block is ready at once.
// Depends on apdf_pkg and apdf_ram.
`timescale 1ns / 1ps
`default_nettype none

module allpass_delay_filter #(
    parameter int MAX_DELAY    = apdf_pkg::DEFAULT_MAX_DELAY,
    parameter int SAMPLE_WIDTH = apdf_pkg::DEFAULT_SAMPLE_WIDTH
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Input samples.
    input  wire logic                                 sample_valid,
    output logic                                      sample_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       sample_in,
    // Filtered samples.
    output logic                                      result_valid,
    input  wire logic                                 result_stall,
    output logic signed [SAMPLE_WIDTH-1:0]            sample_out,
    output logic                                      saturated,
    // Configuration writes.
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [apdf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [apdf_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    import apdf_pkg::*;

    // Sizes derived from the parameters.
    localparam int W      = SAMPLE_WIDTH;
    localparam int AW     = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int CNT_W  = $clog2(MAX_DELAY + 1);
    localparam int EXT_W  = ((DELAY_WIDTH > CNT_W) ? DELAY_WIDTH : CNT_W) + 1;
    localparam int PA_W   = W + GAIN_WIDTH + 1;
    localparam int A_W    = PA_W - FRAC_BITS;
    localparam int G2_W   = 2 * GAIN_WIDTH + 1;
    localparam int K_W    = G2_W - FRAC_BITS;
    localparam int S_W    = A_W + 1;
    localparam int PC_W   = K_W + S_W + 1;
    localparam int C_W    = PC_W - FRAC_BITS;
    localparam int Y_W    = C_W + 1;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SUM  = 2'd2;
    localparam logic [1:0] S_MUL  = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic signed [GAIN_WIDTH-1:0] gain_reg;
    logic [DELAY_WIDTH-1:0]       delay_reg;
    logic [AW-1:0]                pos_reg, pos_next;
    logic [CNT_W-1:0]             fill_reg, fill_next;
    logic                         hist_valid_reg;
    logic signed [W-1:0]          x_reg;
    logic signed [W-1:0]          xd_reg;
    logic signed [A_W-1:0]        a_reg, a_next;
    logic signed [A_W-1:0]        b_reg, b_next;
    logic signed [K_W-1:0]        k_reg, k_next;
    logic signed [S_W-1:0]        s_reg, s_next;
    logic                         result_valid_reg;
    logic signed [W-1:0]          sample_out_reg;
    logic                         saturated_reg;

    logic                         sample_take;
    logic                         result_take;
    logic                         out_free;
    logic                         finish;
    logic                         cfg_write;

    // Read address arithmetic.
    logic [EXT_W-1:0]             delay_ext, eff_delay, pos_ext, rd_ext;
    logic [AW-1:0]                rd_addr;
    logic                         rd_hit;

    // History RAM: {output sample, input sample} per entry.
    logic [2*W-1:0]               ram_rd_data;
    logic [2*W-1:0]               ram_wr_data;

    // Datapath signals.
    logic signed [W-1:0]          xd, yd;
    logic signed [W+GAIN_WIDTH-1:0]   gx_prod, gy_prod;
    logic signed [2*GAIN_WIDTH-1:0]   gg_prod;
    logic signed [PA_W-1:0]       a_sum, b_sum;
    logic signed [G2_W-1:0]       g2_sum;
    logic signed [K_W-1:0]        g2;
    logic signed [K_W+S_W-1:0]    c_prod;
    logic signed [PC_W-1:0]       c_sum;
    logic signed [C_W-1:0]        c_val;
    logic signed [Y_W-1:0]        y_sum;
    logic [Y_W-W:0]               y_high;
    logic                         y_fits;
    logic signed [W-1:0]          y_out;

    // Handshake decode. A configuration write goes ahead of a sample request
    // offered in the same cycle, so the two never land on one edge.
    assign sample_stall = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready    = (state_reg == S_IDLE);
    assign sample_take  = sample_valid && !sample_stall;
    assign result_take  = result_valid_reg && !result_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign finish       = (state_reg == S_MUL) && out_free;
    assign cfg_write    = cfg_valid && cfg_ready;

    assign result_valid = result_valid_reg;
    assign sample_out   = sample_out_reg;
    assign saturated    = saturated_reg;

    // Delayed slot: a zero delay acts as one, a long one is capped at the depth.
    always_comb
    begin
        delay_ext = EXT_W'(delay_reg);
        if (delay_ext == '0)
        begin
            eff_delay = EXT_W'(1);
        end
        else if (delay_ext > EXT_W'(MAX_DELAY))
        begin
            eff_delay = EXT_W'(MAX_DELAY);
        end
        else
        begin
            eff_delay = delay_ext;
        end
        pos_ext = EXT_W'(pos_reg);
        if (pos_ext >= eff_delay)
        begin
            rd_ext = pos_ext - eff_delay;
        end
        else
        begin
            rd_ext = pos_ext + EXT_W'(MAX_DELAY) - eff_delay;
        end
        rd_addr = rd_ext[AW-1:0];
        // Slots at or above the fill count have not been written since clearing.
        rd_hit  = rd_ext < EXT_W'(fill_reg);
    end

    apdf_ram #(
        .WIDTH (2 * W),
        .DEPTH (MAX_DELAY),
        .ADDR_W(AW)
    ) u_hist_ram (
        .clk    (clk),
        .wr_en  (finish),
        .wr_addr(pos_reg),
        .wr_data(ram_wr_data),
        .rd_en  (sample_take),
        .rd_addr(rd_addr),
        .rd_data(ram_rd_data)
    );

    assign ram_wr_data = {y_out, x_reg};

    // Read stage: the three gain products, each rounded to Q1.15.
    always_comb
    begin
        xd      = hist_valid_reg ? $signed(ram_rd_data[W-1:0]) : '0;
        yd      = hist_valid_reg ? $signed(ram_rd_data[2*W-1:W]) : '0;
        gx_prod = gain_reg * x_reg;
        gy_prod = gain_reg * yd;
        gg_prod = gain_reg * gain_reg;
        a_sum   = PA_W'(ROUND_BIAS) - PA_W'(gx_prod);
        b_sum   = PA_W'(gy_prod) + PA_W'(ROUND_BIAS);
        g2_sum  = G2_W'(gg_prod) + G2_W'(ROUND_BIAS);
        a_next  = $signed(a_sum[PA_W-1:FRAC_BITS]);
        b_next  = $signed(b_sum[PA_W-1:FRAC_BITS]);
        g2      = $signed(g2_sum[G2_W-1:FRAC_BITS]);
        k_next  = K_W'(ONE_Q15) - g2;
    end

    // Sum stage: delayed input plus scaled delayed output.
    assign s_next = S_W'(xd_reg) + S_W'(b_reg);

    // Final stage: last product, output sum and saturation.
    always_comb
    begin
        c_prod = k_reg * s_reg;
        c_sum  = PC_W'(c_prod) + PC_W'(ROUND_BIAS);
        c_val  = $signed(c_sum[PC_W-1:FRAC_BITS]);
        y_sum  = Y_W'(a_reg) + Y_W'(c_val);
        y_high = y_sum[Y_W-1:W-1];
        y_fits = (&y_high) || !(|y_high);
        if (y_fits)
        begin
            y_out = $signed(y_sum[W-1:0]);
        end
        else if (y_sum[Y_W-1])
        begin
            y_out = $signed({1'b1, {(W-1){1'b0}}});
        end
        else
        begin
            y_out = $signed({1'b0, {(W-1){1'b1}}});
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_take)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Ring position and fill count advance on each write-back and clear on a delay write.
    always_comb
    begin
        pos_next  = pos_reg;
        fill_next = fill_reg;
        if (cfg_write && (cfg_index == REG_DELAY_LENGTH))
        begin
            pos_next  = '0;
            fill_next = '0;
        end
        else if (finish)
        begin
            pos_next = (pos_reg == AW'(MAX_DELAY - 1)) ? '0 : pos_reg + AW'(1);
            if (fill_reg != CNT_W'(MAX_DELAY))
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            gain_reg         <= '0;
            delay_reg        <= DELAY_RESET;
            pos_reg          <= '0;
            fill_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            fill_reg  <= fill_next;
            if (cfg_write && (cfg_index == REG_GAIN))
            begin
                gain_reg <= $signed(cfg_data[GAIN_WIDTH-1:0]);
            end
            if (cfg_write && (cfg_index == REG_DELAY_LENGTH))
            begin
                delay_reg <= cfg_data[DELAY_WIDTH-1:0];
            end
            if (finish)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_take)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            x_reg          <= sample_in;
            hist_valid_reg <= rd_hit;
        end
        if (state_reg == S_READ)
        begin
            xd_reg <= xd;
            a_reg  <= a_next;
            b_reg  <= b_next;
            k_reg  <= k_next;
        end
        if (state_reg == S_SUM)
        begin
            s_reg <= s_next;
        end
        if (finish)
        begin
            sample_out_reg <= y_out;
            saturated_reg  <= !y_fits;
        end
    end

    // Checks on the sequencer and ring bookkeeping.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_DELAY))
        else $error("fill count above ring depth");

    a_fill_tracks_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != CNT_W'(MAX_DELAY)) |-> (fill_reg == CNT_W'(pos_reg)))
        else $error("fill count and ring position diverged before wrap");

    a_take_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        sample_take |=> (state_reg == S_READ))
        else $error("accepted request did not start a RAM read");

    a_result_from_mul: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_MUL))
        else $error("result appeared without a final stage");

    a_delay_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && (cfg_index == REG_DELAY_LENGTH)) |=>
        ((pos_reg == '0) && (fill_reg == '0)))
        else $error("delay write did not empty the rings");

endmodule

`default_nettype wire
